### rtl/core/ibm_pkg.sv
// ----------------------------------------------------------------------------
// ibm_pkg
// shared types, constants and helpers of the id set membership unit
// ----------------------------------------------------------------------------
`default_nettype none

package ibm_pkg;

  localparam int unsigned MAX_IDS_DEF = 4096;
  localparam int unsigned ID_W        = 64;
  localparam int unsigned CFG_W       = 13;
  localparam int unsigned FIB_W       = 5;
  localparam logic [CFG_W-1:0] CFG_RESET = 13'd4096;

  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_QUERY  = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    STATUS_OK   = 2'd0,
    STATUS_DUP  = 2'd1,
    STATUS_FULL = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_FILT,
    S_PROBE,
    S_RESULT
  } state_e;

  // filter index width: ceil(log2(min(count, max_ids))) + 5
  function automatic logic [FIB_W-1:0] derive_bits(input logic [CFG_W-1:0] count,
                                                   input int unsigned max_ids);
    logic [20:0] c;
    logic [FIB_W-1:0] b;
    c = (21'(count) > 21'(max_ids)) ? 21'(max_ids) : 21'(count);
    b = '0;
    for (int i = 0; i < 21; i++) begin
      if ((21'd1 << i) < c) begin
        b = FIB_W'(i + 1);
      end
    end
    return FIB_W'(b + FIB_W'(5));
  endfunction

endpackage

`default_nettype wire

### rtl/core/ibm_if.sv
// ----------------------------------------------------------------------------
// ibm_if
// handshake channels of the id set membership unit
// ----------------------------------------------------------------------------
`default_nettype none

interface ibm_in_if;
  logic               valid;
  logic               ready;
  logic               cmd;
  logic signed [63:0] id;
  modport source (output valid, cmd, id, input ready);
  modport sink   (input valid, cmd, id, output ready);
endinterface

interface ibm_out_if;
  logic       valid;
  logic       ready;
  logic       member;
  logic       filter_hit;
  logic [1:0] status;
  modport source (output valid, member, filter_hit, status, input ready);
  modport sink   (input valid, member, filter_hit, status, output ready);
endinterface

interface ibm_cfg_if;
  logic        valid;
  logic        ready;
  logic [12:0] expected_count;
  modport source (output valid, expected_count, input ready);
  modport sink   (input valid, expected_count, output ready);
endinterface

`default_nettype wire

### rtl/core/ibm_ram.sv
// ----------------------------------------------------------------------------
// ibm_ram
// single write port, single read port ram with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module ibm_ram #(
  parameter int unsigned W     = 8,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = 4
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire logic [W-1:0]  wdata_i,
  input  wire logic [AW-1:0] raddr_i,
  output logic      [W-1:0]  rdata_o
);

  logic [W-1:0] mem [DEPTH];
  logic [W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### rtl/core/id_set_bloom_membership_unit.sv
// ----------------------------------------------------------------------------
// id_set_bloom_membership_unit
// 64-bit id set with a single-hash bloom prefilter and an exact id table
// ----------------------------------------------------------------------------
// Items are handled one at a time. After its transfer an item passes S_FILT,
// where the prefilter or the home slot of the open-addressed id table may
// settle it (a query whose filter bit is clear, an insert into a full table
// with a clear bit, or a match or an empty entry in the home slot), then
// S_PROBE once for each further slot probed; the table's single read port
// sets that pace, and a full table costs up to MAX_IDS probes. The result
// is then held in S_RESULT and loaded into the output register once that
// register is free. A new item is taken in the cycle after the result is
// loaded, so a result waiting on out_o.ready holds the next item off.
// After reset and after every write of expected_count the filter and table
// rams are swept clear, one entry a cycle, over all 2^(clog2(MAX_IDS)+2)
// filter entries (16384 at the default), and no item is taken meanwhile.
`default_nettype none

module id_set_bloom_membership_unit #(
  parameter int unsigned MAX_IDS = ibm_pkg::MAX_IDS_DEF
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  ibm_in_if.sink     in_i,
  ibm_out_if.source  out_o,
  ibm_cfg_if.sink    cfg_i
);

  import ibm_pkg::*;

  localparam int unsigned TW     = (MAX_IDS > 1) ? $clog2(MAX_IDS) : 1;
  localparam int unsigned CNT_W  = $clog2(MAX_IDS + 1);
  localparam int unsigned FB_W   = $clog2(MAX_IDS) + 5;
  localparam int unsigned FA_W   = FB_W - 3;
  localparam int unsigned FDEPTH = 2 ** FA_W;
  localparam int unsigned TDW    = ID_W + 1;

  localparam logic [TW:0]      SLOT_LIM  = (TW + 1)'(MAX_IDS);
  localparam logic [TW-1:0]    LAST_SLOT = TW'(MAX_IDS - 1);
  localparam logic [CNT_W-1:0] CNT_FULL  = CNT_W'(MAX_IDS);
  localparam logic [CNT_W-1:0] LAST_PRB  = CNT_W'(MAX_IDS - 1);
  localparam logic [FA_W-1:0]  CLR_LAST  = FA_W'(FDEPTH - 1);
  localparam logic [FA_W:0]    CLR_TLIM  = (FA_W + 1)'(MAX_IDS);

  function automatic logic [TW-1:0] slot_of(input logic [ID_W-1:0] v);
    logic [TW:0] h;
    h = {1'b0, v[TW-1:0] ^ v[2*TW-1:TW]};
    if (h >= SLOT_LIM) begin
      h = h - SLOT_LIM;
    end
    return h[TW-1:0];
  endfunction

  state_e state_q, state_d;

  logic [FIB_W-1:0] fib_q;
  logic [FA_W-1:0]  clr_q;
  logic [CNT_W-1:0] count_q;
  logic [CNT_W-1:0] nprobe_q;
  logic [TW-1:0]    slot_q;
  logic [ID_W-1:0]  id_q;
  cmd_e             cmd_q;
  logic             hit_q;

  logic    res_member_q, res_hit_q;
  status_e res_status_q;
  logic    out_valid_q, out_member_q, out_hit_q;
  status_e out_status_q;

  // evaluation of the current cycle
  logic [FB_W-1:0] mask, pos_in, pos_held;
  logic [7:0]      fdata;
  logic [TDW-1:0]  tdata;
  logic            f_hit, hit_w, t_match, t_empty, t_last;
  logic            done, advance, do_ins, res_member;
  status_e         res_status;
  logic [TW-1:0]   next_slot;
  logic            out_free, in_xfer, clr_end;

  // ram ports
  logic            f_we, t_we;
  logic [FA_W-1:0] f_waddr, f_raddr;
  logic [7:0]      f_wdata;
  logic [TW-1:0]   t_waddr, t_raddr;
  logic [TDW-1:0]  t_wdata;

  assign mask      = ~({FB_W{1'b1}} << fib_q);
  assign pos_in    = in_i.id[FB_W-1:0] & mask;
  assign pos_held  = id_q[FB_W-1:0] & mask;
  assign next_slot = (slot_q == LAST_SLOT) ? '0 : TW'(slot_q + 1'b1);
  assign out_free  = !out_valid_q || out_o.ready;
  assign in_xfer   = in_i.valid && in_i.ready;
  assign clr_end   = (clr_q == CLR_LAST);

  always_comb begin
    f_hit      = fdata[pos_held[2:0]];
    hit_w      = (state_q == S_FILT) ? f_hit : hit_q;
    t_match    = tdata[TDW-1] && (tdata[ID_W-1:0] == id_q);
    t_empty    = !tdata[TDW-1];
    t_last     = (nprobe_q == LAST_PRB);
    done       = 1'b0;
    advance    = 1'b0;
    do_ins     = 1'b0;
    res_member = 1'b0;
    res_status = STATUS_OK;
    if (state_q == S_FILT && cmd_q == CMD_QUERY && !f_hit) begin
      done = 1'b1;
    end else if (state_q == S_FILT && cmd_q == CMD_INSERT && !f_hit
                 && count_q == CNT_FULL) begin
      done       = 1'b1;
      res_status = STATUS_FULL;
    end else if (state_q == S_FILT || state_q == S_PROBE) begin
      if (t_match) begin
        done = 1'b1;
        if (cmd_q == CMD_QUERY) begin
          res_member = 1'b1;
        end else begin
          res_status = STATUS_DUP;
        end
      end else if (t_empty) begin
        done   = 1'b1;
        do_ins = (cmd_q == CMD_INSERT);
      end else if (t_last) begin
        // every slot probed: the table is full
        done = 1'b1;
        if (cmd_q == CMD_INSERT) begin
          res_status = STATUS_FULL;
        end
      end else begin
        advance = 1'b1;
      end
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR:  if (clr_end) state_d = S_IDLE;
      S_IDLE:   if (in_xfer) state_d = S_FILT;
      S_FILT,
      S_PROBE: begin
        if (done) begin
          state_d = S_RESULT;
        end else if (advance) begin
          state_d = S_PROBE;
        end
      end
      S_RESULT: if (out_free) state_d = S_IDLE;
      default:  state_d = S_CLEAR;
    endcase
    if (cfg_i.valid) begin
      state_d = S_CLEAR;
    end
  end

  // fsm outputs and ram ports
  always_comb begin
    in_i.ready  = 1'b0;
    f_we        = 1'b0;
    f_waddr     = pos_held[FB_W-1:3];
    f_wdata     = fdata | (8'd1 << pos_held[2:0]);
    f_raddr     = pos_held[FB_W-1:3];
    t_we        = 1'b0;
    t_waddr     = slot_q;
    t_wdata     = {1'b1, id_q};
    t_raddr     = advance ? next_slot : slot_q;
    case (state_q)
      S_CLEAR: begin
        f_we    = 1'b1;
        f_waddr = clr_q;
        f_wdata = '0;
        t_we    = ({1'b0, clr_q} < CLR_TLIM);
        t_waddr = clr_q[TW-1:0];
        t_wdata = '0;
      end
      S_IDLE: begin
        in_i.ready = 1'b1;
        f_raddr    = pos_in[FB_W-1:3];
        t_raddr    = slot_of(in_i.id);
      end
      S_FILT,
      S_PROBE: begin
        f_we = do_ins;
        t_we = do_ins;
      end
      S_RESULT: ;
      default: ;
    endcase
  end

  assign cfg_i.ready = 1'b1;

  ibm_ram #(.W(8), .DEPTH(FDEPTH), .AW(FA_W)) u_filter_ram (
    .clk_i   (clk_i),
    .we_i    (f_we),
    .waddr_i (f_waddr),
    .wdata_i (f_wdata),
    .raddr_i (f_raddr),
    .rdata_o (fdata)
  );

  ibm_ram #(.W(TDW), .DEPTH(MAX_IDS), .AW(TW)) u_table_ram (
    .clk_i   (clk_i),
    .we_i    (t_we),
    .waddr_i (t_waddr),
    .wdata_i (t_wdata),
    .raddr_i (t_raddr),
    .rdata_o (tdata)
  );

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      fib_q       <= derive_bits(CFG_RESET, MAX_IDS);
      clr_q       <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_CLEAR) begin
        clr_q <= FA_W'(clr_q + 1'b1);
      end
      if (do_ins) begin
        count_q <= CNT_W'(count_q + 1'b1);
      end
      if (state_q == S_RESULT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_i.valid) begin
        fib_q   <= derive_bits(cfg_i.expected_count, MAX_IDS);
        clr_q   <= '0;
        count_q <= '0;
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      id_q     <= in_i.id;
      cmd_q    <= cmd_e'(in_i.cmd);
      slot_q   <= slot_of(in_i.id);
      nprobe_q <= '0;
    end
    if (state_q == S_FILT) begin
      hit_q <= f_hit;
    end
    if (advance) begin
      slot_q   <= next_slot;
      nprobe_q <= CNT_W'(nprobe_q + 1'b1);
    end
    if (done) begin
      res_member_q <= res_member;
      res_hit_q    <= hit_w;
      res_status_q <= res_status;
    end
    if (state_q == S_RESULT && out_free) begin
      out_member_q <= res_member_q;
      out_hit_q    <= res_hit_q;
      out_status_q <= res_status_q;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.member     = out_member_q;
  assign out_o.filter_hit = out_hit_q;
  assign out_o.status     = out_status_q;

endmodule

`default_nettype wire

### test/ibm_tb_checker.sv
// ----------------------------------------------------------------------------
// ibm_tb_checker
// watches the channels of the id set membership unit, predicts each result
// from its own copy of the set and compares it field by field
// ----------------------------------------------------------------------------
`default_nettype none

module ibm_tb_checker (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  ibm_in_if         in_i,
  ibm_out_if        out_i,
  ibm_cfg_if        cfg_i,
  output int        fail_count_o,
  output int        pending_o
);

  import ibm_pkg::*;

  localparam int unsigned SET_CAP = MAX_IDS_DEF;

  typedef struct packed {
    logic    member;
    logic    hit;
    status_e status;
  } verdict_t;

  logic [CFG_W-1:0] count_reg;
  int unsigned      index_bits;
  bit [131071:0]    filter_map;
  bit               id_known [logic [63:0]];
  int unsigned      n_stored;
  verdict_t         verdict_q [$];
  int               mismatches;

  function automatic int unsigned width_for(logic [CFG_W-1:0] count);
    int unsigned c;
    int unsigned b;
    c = (count > SET_CAP) ? SET_CAP : count;
    b = 0;
    while (b < 40 && c > (64'd1 << b)) b++;
    return b + 5;
  endfunction

  function automatic void empty_set();
    filter_map = '0;
    id_known.delete();
    n_stored   = 0;
    index_bits = width_for(count_reg);
  endfunction

  function automatic verdict_t lookup_and_update(cmd_e op, logic [63:0] id);
    verdict_t v;
    int unsigned pos;
    bit stored;
    pos      = int'(id & ((64'd1 << index_bits) - 1));
    v.hit    = filter_map[pos];
    v.member = 1'b0;
    v.status = STATUS_OK;
    stored   = v.hit && id_known.exists(id);
    if (op == CMD_INSERT) begin
      if (stored) begin
        v.status = STATUS_DUP;
      end else if (n_stored >= SET_CAP) begin
        v.status = STATUS_FULL;
      end else begin
        id_known[id]    = 1'b1;
        n_stored++;
        filter_map[pos] = 1'b1;
      end
    end else begin
      v.member = stored;
    end
    return v;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    verdict_t want;
    if (!rst_ni) begin
      count_reg  = CFG_RESET;
      empty_set();
      verdict_q.delete();
      fail_count_o <= 0;
      mismatches  = 0;
    end else begin
      if (cfg_i.valid && cfg_i.ready) begin
        count_reg = cfg_i.expected_count;
        empty_set();
      end
      if (in_i.valid && in_i.ready) begin
        verdict_q = {verdict_q, lookup_and_update(cmd_e'(in_i.cmd), in_i.id)};
      end
      if (out_i.valid && out_i.ready) begin
        if (verdict_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result at %0t", $time);
        end else begin
          want = verdict_q.pop_front();
          if (want.member !== out_i.member || want.hit !== out_i.filter_hit ||
              want.status !== out_i.status) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch at %0t: exp member %0d hit %0d status %0d, got %0d %0d %0d",
                       $time, want.member, want.hit, want.status,
                       out_i.member, out_i.filter_hit, out_i.status);
          end
        end
      end
      fail_count_o <= mismatches;
    end
    pending_o <= verdict_q.size();
  end

  // anything still waiting at the end is counted by the top through pending_o

endmodule

`default_nettype wire

### test/id_set_bloom_membership_unit_tb.sv
// ----------------------------------------------------------------------------
// id_set_bloom_membership_unit_tb
// drives inserts, queries and expected_count writes into the membership unit
// under several idle and stall mixes; the checker predicts and compares
// ----------------------------------------------------------------------------
`default_nettype none

module id_set_bloom_membership_unit_tb;
  import ibm_pkg::*;

  localparam longint CYCLE_LIMIT = 40_000_000;

  logic clk_i;
  logic rst_ni;
  int   fail_count;
  int   pending;
  int   send_idle;
  int   recv_stall;
  int   hold_left;
  longint cycles;
  logic [63:0] id_pool [$];

  ibm_in_if  in_ch ();
  ibm_out_if out_ch ();
  ibm_cfg_if cfg_ch ();

  id_set_bloom_membership_unit u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch),
    .out_o (out_ch),
    .cfg_i (cfg_ch)
  );

  ibm_tb_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_ch),
    .out_i       (out_ch),
    .cfg_i       (cfg_ch),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("id_set_bloom_membership_unit_tb: FAIL");
      $finish;
    end
  end

  // result side: random stalls plus an optional long hold-off
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_ch.ready <= 1'b0;
      hold_left--;
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) >= recv_stall);
    end
  end

  task automatic send_item(cmd_e op, logic [63:0] id);
    if (send_idle > 0 && $urandom_range(0, 99) < send_idle) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(0, 99) < send_idle) @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.cmd   <= op;
    in_ch.id    <= id;
    do @(posedge clk_i); while (!in_ch.ready);
    if (op == CMD_INSERT) id_pool = {id_pool, id};
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  task automatic write_count(logic [CFG_W-1:0] value);
    drain();
    cfg_ch.valid          <= 1'b1;
    cfg_ch.expected_count <= value;
    do @(posedge clk_i); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
  endtask

  // mix of repeats, low-bit aliases of stored ids, small ids and random ids
  function automatic logic [63:0] pick_id();
    int r;
    r = $urandom_range(0, 9);
    if (r < 3 && id_pool.size() > 0)
      return id_pool[$urandom_range(0, id_pool.size() - 1)];
    if (r < 5 && id_pool.size() > 0)
      return id_pool[$urandom_range(0, id_pool.size() - 1)] ^ ({$urandom, $urandom} << 17);
    if (r == 5) return 64'($urandom_range(0, 63));
    return {$urandom, $urandom};
  endfunction

  task automatic random_run(int n_items);
    for (int k = 0; k < n_items; k++) begin
      if (k == n_items / 3) hold_left = 400;
      if (k == n_items / 2) drain();
      send_item(cmd_e'($urandom_range(0, 1)), pick_id());
    end
  endtask

  initial begin
    logic [CFG_W-1:0] counts [5];
    int idle_mix  [4];
    int stall_mix [4];
    counts                = '{13'd0, 13'd1, 13'd8191, 13'd2, 13'd100};
    idle_mix              = '{0, 73, 0, 20};
    stall_mix             = '{0, 0, 73, 20};
    rst_ni                = 1'b0;
    cycles                = 0;
    hold_left             = 0;
    send_idle             = 0;
    recv_stall            = 0;
    in_ch.valid           = 1'b0;
    in_ch.cmd             = CMD_INSERT;
    in_ch.id              = '0;
    cfg_ch.valid          = 1'b0;
    cfg_ch.expected_count = CFG_RESET;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: extreme ids, duplicates, filter aliases
    send_item(CMD_QUERY, 64'd0);
    send_item(CMD_INSERT, 64'd0);
    send_item(CMD_INSERT, 64'd0);
    send_item(CMD_INSERT, '1);
    send_item(CMD_INSERT, 64'h7fff_ffff_ffff_ffff);
    send_item(CMD_INSERT, 64'h8000_0000_0000_0000);
    send_item(CMD_QUERY, 64'h8000_0000_0000_0000);
    send_item(CMD_QUERY, 64'd0);
    send_item(CMD_QUERY, '1);
    send_item(CMD_QUERY, 64'd1 << 17);
    send_item(CMD_INSERT, 64'd1 << 17);
    send_item(CMD_QUERY, 64'd1 << 17);
    send_item(CMD_QUERY, 64'd5);
    send_item(CMD_INSERT, 64'h7fff_ffff_ffff_ffff);

    for (int p = 0; p < 5; p++) begin
      write_count(counts[p]);
      send_idle  = idle_mix[p % 4];
      recv_stall = stall_mix[p % 4];
      send_item(CMD_INSERT, 64'd32);
      send_item(CMD_QUERY, 64'd0);
      random_run(290);
    end

    // back to the full count, then mixed inserts and queries
    send_idle  = 0;
    recv_stall = 0;
    write_count(13'd4096);
    send_idle  = 20;
    recv_stall = 20;
    send_item(CMD_INSERT, 64'd0);
    send_item(CMD_INSERT, 64'd3 * 64'h9e37_79b9_7f4a_7c15);
    for (int k = 0; k < 20; k++) begin
      send_item(CMD_INSERT, {$urandom, $urandom});
      send_item(CMD_QUERY, 64'($urandom_range(0, 4095)) * 64'h9e37_79b9_7f4a_7c15);
      send_item(CMD_QUERY, {$urandom, $urandom});
    end

    drain();
    if (fail_count == 0 && pending == 0) begin
      $display("id_set_bloom_membership_unit_tb: PASS");
    end else begin
      $display("id_set_bloom_membership_unit_tb: FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
